// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
// This file has no dependencies. The interfaces, the controller, the
// datapath and the top level all use it.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of every field on the external channels.
  localparam int unsigned FIELD_W = 32;

  // Modulus value loaded at reset. Only the low operand bits are kept.
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd123456;

  // States of the sequencing controller.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_RED,
    ST_CHECK,
    ST_ACC_MUL,
    ST_ACC_RED,
    ST_SQ_MUL,
    ST_SQ_RED,
    ST_DONE
  } mexp_state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MS_INIT,
    MS_ACC,
    MS_SQ
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul;
    mul_sel_t sel;
    logic     red;
    logic     wr_acc;
    logic     wr_sq;
    logic     init_acc;
    logic     shift;
    logic     out_load;
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic red_last;
    logic bit_done;
  } mexp_sts_t;

endpackage

// ===== rtl/core/mexp_ifs.sv =====
// Valid/ready channel interfaces of the modular exponentiation unit.
// Depends on mexp_pkg for the field width.
`timescale 1ns / 1ps

// Input channel: one beat carries a base and an exponent.
interface mexp_in_if
  import mexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

// Result channel: one beat carries one reduced power.
interface mexp_out_if
  import mexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

// Configuration channel: one beat writes the modulus register.
interface mexp_cfg_if
  import mexp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

// ===== rtl/core/mexp_dp.sv =====
// Datapath of the modular exponentiation unit: operand registers, one
// shared multiplier and a bit-serial shift-and-subtract reducer.
// Depends on mexp_pkg for the command and status structs.
`timescale 1ns / 1ps

module mexp_dp
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mexp_cmd_t                cmd,
  output mexp_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [OPERAND_WIDTH-1:0] cfg_modulus,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  output logic [OPERAND_WIDTH-1:0] power_result
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned CNT_W = $clog2(PW);
  localparam int unsigned STP_W = $clog2(W + 1);

  logic [W-1:0]     mod_r;
  logic [W-1:0]     sq_r, sq_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     exp_r, exp_nxt;
  logic [STP_W-1:0] step_r, step_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     out_r;

  logic [W-1:0] mul_a, mul_b;
  logic [W:0]   rem_sh;
  logic [W-1:0] red_res;
  logic         m_small;

  // A modulus of zero or one reduces everything to zero.
  assign m_small = (mod_r[W-1:1] == '0);

  // Modulus register, written through the configuration channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RESET[W-1:0];
    end else if (cfg_we) begin
      mod_r <= cfg_modulus;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.sel)
      MS_INIT: begin
        mul_a = sq_r;
        mul_b = W'(1);
      end
      MS_ACC: begin
        mul_a = acc_r;
        mul_b = sq_r;
      end
      MS_SQ: begin
        mul_a = sq_r;
        mul_b = sq_r;
      end
      default: begin
        mul_a = sq_r;
        mul_b = sq_r;
      end
    endcase
  end

  // One remainder step: bring in the next product bit, subtract if it fits.
  assign rem_sh  = {rem_r[W-1:0], prod_r[PW-1]};
  assign red_res = m_small ? '0 : rem_nxt[W-1:0];

  always_comb begin
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (cmd.mul) begin
      prod_nxt = PW'(mul_a) * PW'(mul_b);
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end else if (cmd.red) begin
      prod_nxt = {prod_r[PW-2:0], 1'b0};
      rem_nxt  = (rem_sh >= {1'b0, mod_r}) ? (rem_sh - {1'b0, mod_r}) : rem_sh;
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  // Operand register updates.
  always_comb begin
    sq_nxt   = sq_r;
    acc_nxt  = acc_r;
    exp_nxt  = exp_r;
    step_nxt = step_r;
    if (cmd.load) begin
      sq_nxt   = in_base;
      exp_nxt  = in_exponent;
      step_nxt = '0;
    end
    if (cmd.wr_sq) begin
      sq_nxt = red_res;
    end
    if (cmd.init_acc) begin
      acc_nxt = m_small ? '0 : W'(1);
    end else if (cmd.wr_acc) begin
      acc_nxt = red_res;
    end
    if (cmd.shift) begin
      exp_nxt  = exp_r >> 1;
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    exp_r  <= exp_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (cmd.out_load) begin
      out_r <= acc_r;
    end
  end

  assign power_result = out_r;

  // Status toward the controller.
  always_comb begin
    sts.exp_zero = (exp_r == '0);
    sts.exp_lsb  = exp_r[0];
    sts.red_last = (cnt_r == CNT_W'(PW - 1));
    sts.bit_done = (step_r == STP_W'(W));
  end

  // Every value written back from the reducer is below the modulus.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_acc && !m_small && !cfg_we |=> acc_r < mod_r)
    else $error("accumulator not reduced");

  a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sq && !m_small && !cfg_we |=> sq_r < mod_r)
    else $error("running square not reduced");

  // The partial remainder stays below the modulus after every step.
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red && !m_small && !cfg_we |=> rem_r < {1'b0, mod_r})
    else $error("partial remainder not reduced");

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// Sequencing controller of the modular exponentiation unit: walks the
// exponent bits and drives the datapath through each modular multiply.
// Depends on mexp_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps

module mexp_ctrl
  import mexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  mexp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_INIT_MUL;
      end
      ST_INIT_MUL: state_nxt = ST_INIT_RED;
      ST_INIT_RED: begin
        if (sts.red_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.exp_zero || sts.bit_done) begin
          state_nxt = ST_DONE;
        end else if (sts.exp_lsb) begin
          state_nxt = ST_ACC_MUL;
        end else begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_ACC_MUL: state_nxt = ST_ACC_RED;
      ST_ACC_RED: begin
        if (sts.red_last) state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL: state_nxt = ST_SQ_RED;
      ST_SQ_RED: begin
        if (sts.red_last) state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    cmd.sel  = MS_SQ;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_INIT_MUL: begin
        cmd.mul = 1'b1;
        cmd.sel = MS_INIT;
      end
      ST_INIT_RED: begin
        cmd.red      = 1'b1;
        cmd.wr_sq    = sts.red_last;
        cmd.init_acc = sts.red_last;
      end
      ST_ACC_MUL: begin
        cmd.mul = 1'b1;
        cmd.sel = MS_ACC;
      end
      ST_ACC_RED: begin
        cmd.red    = 1'b1;
        cmd.wr_acc = sts.red_last;
      end
      ST_SQ_MUL: begin
        cmd.mul = 1'b1;
        cmd.sel = MS_SQ;
      end
      ST_SQ_RED: begin
        cmd.red   = 1'b1;
        cmd.wr_sq = sts.red_last;
        cmd.shift = sts.red_last;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid flag: set when a result is loaded, cleared when taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A pending result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && !out_ready |=> state_r == ST_DONE)
    else $error("result overwritten while pending");

  // New items are taken only when no reduction is running.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.red && !cmd.mul)
    else $error("input accepted during a multiply");

  // An accepted beat always starts with the base reduction.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_INIT_MUL)
    else $error("accepted beat did not start work");

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit (right-to-left
// square-and-multiply). Depends on mexp_pkg, mexp_ifs, mexp_ctrl, mexp_dp.
//
//   Channel  Dir  Payload                 Notes
//   in_if    in   base, exponent          one beat per computation
//   out_if   out  power_result            one beat per input beat
//   cfg_if   in   modulus                 always ready; write only when idle
//
// Each modular multiply is one multiplier step followed by the reducer,
// which works out one remainder bit per cycle over the double-width
// product. Reset is synchronous and active low; the modulus returns to
// 123456. The input is taken again once the result sits in the output
// register, so a stalled output holds at most one item back.
`timescale 1ns / 1ps

module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  mexp_in_if.sink           in_if,
  mexp_out_if.source        out_if,
  mexp_cfg_if.sink          cfg_if
);

  mexp_cmd_t                cmd;
  mexp_sts_t                sts;
  logic [OPERAND_WIDTH-1:0] power_result;

  // Configuration writes are taken in any cycle.
  assign cfg_if.ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_if.valid),
    .cfg_modulus  (cfg_if.modulus[OPERAND_WIDTH-1:0]),
    .in_base      (in_if.base[OPERAND_WIDTH-1:0]),
    .in_exponent  (in_if.exponent[OPERAND_WIDTH-1:0]),
    .power_result (power_result)
  );

  // Results are zero-extended to the channel width.
  assign out_if.power_result = FIELD_W'(power_result);

endmodule

// ===== test/modular_exponentiation_unit_test.sv =====
// Self-checking testbench for modular_exponentiation_unit: drives base and exponent beats,
// rewrites the modulus between phases and checks every power against its own predictor.
// Depends on mexp_pkg, the mexp_ifs interfaces and the RTL of the unit.
`timescale 1ns / 1ps

module modular_exponentiation_unit_test;
  import mexp_pkg::*;

  localparam int unsigned OP_W = 32;

  // Predicts powers from the accepted operand beats and holds them in arrival order.
  class power_book;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] pending_powers[$];
    int unsigned        mismatches;
    int unsigned        powers_checked;

    function new();
      modulus = MODULUS_RESET;
      mismatches = 0;
      powers_checked = 0;
    endfunction

    function void set_modulus(logic [FIELD_W-1:0] value);
      modulus = value;
    endfunction

    function int unsigned pending();
      return pending_powers.size();
    endfunction

    // Right-to-left square-and-multiply; a modulus below two reduces everything to zero.
    function logic [FIELD_W-1:0] predict_power(logic [FIELD_W-1:0] base_in,
                                               logic [FIELD_W-1:0] exp_in);
      logic [FIELD_W-1:0] op_mask;
      logic [FIELD_W-1:0] m;
      logic [FIELD_W-1:0] square;
      logic [FIELD_W-1:0] acc;
      logic [FIELD_W-1:0] rest;
      logic [63:0]        prod;
      int unsigned        steps;
      op_mask = {FIELD_W{1'b1}} >> (FIELD_W - OP_W);
      m = modulus & op_mask;
      if (m < 2) begin
        return '0;
      end
      square = (base_in & op_mask) % m;
      acc = 1;
      rest = exp_in & op_mask;
      for (steps = 0; steps < OP_W && rest != 0; steps++) begin
        if (rest[0]) begin
          prod = 64'(acc) * 64'(square);
          acc = FIELD_W'(prod % 64'(m));
        end
        prod = 64'(square) * 64'(square);
        square = FIELD_W'(prod % 64'(m));
        rest = rest >> 1;
      end
      return acc;
    endfunction

    function void note_operands(logic [FIELD_W-1:0] base_in, logic [FIELD_W-1:0] exp_in);
      pending_powers.push_back(predict_power(base_in, exp_in));
    endfunction

    function void check_power(logic [FIELD_W-1:0] actual);
      logic [FIELD_W-1:0] wanted;
      powers_checked++;
      if (pending_powers.size() == 0) begin
        mismatches++;
        $display("%0t: power_result with no pending item, expected none, actual %h",
                 $time, actual);
      end else begin
        wanted = pending_powers.pop_front();
        if (actual !== wanted) begin
          mismatches++;
          $display("%0t: power_result mismatch, expected %h, actual %h",
                   $time, wanted, actual);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mexp_in_if  in_if ();
  mexp_out_if out_if ();
  mexp_cfg_if cfg_if ();

  power_book   book;
  bit          idle_on;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned settings_used;

  modular_exponentiation_unit #(
    .OPERAND_WIDTH(OP_W)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15_000_000;
    $display("modular_exponentiation_unit_test: done, errors");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      out_if.ready <= (hold_left == 0);
    end
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      book.check_power(out_if.power_result);
    end
  end

  // Sends one operand beat, optionally after an idle burst, and records it once accepted.
  task automatic send_operands(logic [FIELD_W-1:0] base_val, logic [FIELD_W-1:0] exp_val);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.base     <= base_val;
    in_if.exponent <= exp_val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book.note_operands(base_val, exp_val);
    items_sent++;
  endtask

  // Lowers valid once the last operand beat has gone.
  task automatic stop_operands();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Waits until every predicted power has come back, then a few more cycles.
  task automatic wait_for_powers();
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the modulus; the caller makes sure the unit is idle.
  task automatic write_modulus(logic [FIELD_W-1:0] value);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.modulus <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    book.set_modulus(value);
    settings_used++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random operands: mostly short exponents, some full-width ones and some edge values.
  task automatic send_random_operands();
    logic [FIELD_W-1:0] base_val;
    logic [FIELD_W-1:0] exp_val;
    int unsigned        len;
    case ($urandom_range(0, 9))
      0: base_val = '0;
      1: base_val = '1;
      2: base_val = $urandom_range(0, 15);
      3: base_val = book.modulus + $urandom_range(0, 2) - 1;
      default: base_val = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: exp_val = '0;
      1: exp_val = '1;
      2: exp_val = $urandom;
      default: begin
        len = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12) : $urandom_range(1, 32);
        exp_val = $urandom;
        if (len < 32) begin
          exp_val = exp_val & ((32'd1 << len) - 1);
        end
        exp_val[len-1] = 1'b1;
      end
    endcase
    send_operands(base_val, exp_val);
  endtask

  // Reset, directed cases, random phases with fresh moduli, drain and report.
  initial begin
    logic [FIELD_W-1:0] mod_val;
    int unsigned        phase;
    int unsigned        n;
    book = new();
    idle_on = 1'b1;
    items_sent = 0;
    settings_used = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.base = '0;
    in_if.exponent = '0;
    cfg_if.valid = 1'b0;
    cfg_if.modulus = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset modulus: zero exponent, zero base, full-width operands and a base of the modulus.
    send_operands(32'd0, 32'd0);
    send_operands(32'd5, 32'd0);
    send_operands(32'd0, 32'd1);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'd123456, 32'd1);
    send_operands(32'd123457, 32'd1);
    send_operands(32'd2, 32'd31);
    send_operands(32'd3, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'd2);
    stop_operands();
    wait_for_powers();

    // Largest modulus.
    write_modulus(32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'd5);
    send_operands(32'h1234_5678, 32'd0);
    stop_operands();
    wait_for_powers();

    // Smallest legal modulus.
    write_modulus(32'd2);
    send_operands(32'd7, 32'hFFFF_FFFF);
    send_operands(32'd6, 32'd3);
    send_operands(32'd9, 32'd0);
    stop_operands();
    wait_for_powers();

    // A modulus of one reduces everything, the zero exponent included, to zero.
    write_modulus(32'd1);
    send_operands(32'd5, 32'd0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stop_operands();
    wait_for_powers();

    // A modulus of zero behaves like a modulus of one.
    write_modulus(32'd0);
    send_operands(32'd5, 32'd0);
    send_operands(32'd3, 32'd7);
    stop_operands();
    wait_for_powers();

    // Power-of-two modulus at the top bit.
    write_modulus(32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_operands(32'h8000_0001, 32'd3);
    stop_operands();
    wait_for_powers();

    // Random phases, each under a new modulus; the last one runs without idling.
    for (phase = 0; phase < 10; phase++) begin
      case ((phase == 0) ? 0 : $urandom_range(0, 4))
        0: mod_val = $urandom;
        1: mod_val = $urandom_range(2, 300);
        2: mod_val = $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
        3: mod_val = 32'd1 << $urandom_range(1, 31);
        default: mod_val = $urandom | 32'h8000_0001;
      endcase
      if (mod_val < 2) begin
        mod_val = 2;
      end
      write_modulus(mod_val);
      idle_on = (phase != 9) && ($urandom_range(0, 4) != 0);
      for (n = 0; n < 26; n++) begin
        send_random_operands();
      end
      stop_operands();
      wait_for_powers();
    end

    // Extra cycles catch any stray result beat.
    repeat (200) @(posedge clk);
    $display("Sent %0d operand beats under %0d modulus writes; checked %0d power results.",
             items_sent, settings_used, book.powers_checked);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("modular_exponentiation_unit_test: done, clean");
    end else begin
      $display("modular_exponentiation_unit_test: done, errors");
    end
    $finish;
  end

endmodule
